// ----- src/mtf_pkg.sv -----
// ----------------------------------------------------------------------------
// mtf_pkg: shared types for the move-to-front LRU cache
// Request and response words, the per-slot entry word and the control
// broadcast that every cell of the row sees.
// ----------------------------------------------------------------------------
package mtf_pkg;

	localparam int KEY_W = 32;
	localparam int PAY_W = 32;

	typedef enum logic {
		ACT_LOOKUP = 1'b0,
		ACT_INSERT = 1'b1
	} action_t;

	typedef struct packed {
		action_t            action;
		logic [KEY_W-1:0]   key;
		logic [PAY_W-1:0]   payload;
	} req_t;

	typedef struct packed {
		logic               hit;
		logic [PAY_W-1:0]   found_payload;
		logic               released_valid;
		logic [PAY_W-1:0]   released_payload;
	} rsp_t;

	typedef struct packed {
		logic               valid;
		logic [KEY_W-1:0]   key;
		logic [PAY_W-1:0]   payload;
	} entry_t;

	// Broadcast to every cell during the update cycle.
	typedef struct packed {
		logic               active;
		logic               hit;
		logic               insert;
		logic [KEY_W-1:0]   key;
	} cell_ctl_t;

endpackage

// ----- src/mtf_cell.sv -----
// ----------------------------------------------------------------------------
// mtf_cell: one slot of the ordered cache row
// Holds one entry, compares it with the request key, passes the first-match
// flag and the matched payload down the row, and loads its upper neighbor.
// ----------------------------------------------------------------------------
module mtf_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mtf_pkg::cell_ctl_t          ctl,
	input  mtf_pkg::entry_t             prev,
	input  logic                        found_in,
	input  logic [mtf_pkg::PAY_W-1:0]   sel_in,
	output mtf_pkg::entry_t             entry,
	output logic                        found_out,
	output logic [mtf_pkg::PAY_W-1:0]   sel_out
);
	import mtf_pkg::*;

	entry_t entry_q;
	logic   match;
	logic   first;
	logic   load;

	assign match     = entry_q.valid && (entry_q.key == ctl.key);
	assign first     = match && !found_in;
	assign found_out = found_in || match;
	assign sel_out   = sel_in | (first ? entry_q.payload : '0);

	// On a hit, every slot up to the matched one shifts back; on an insert
	// miss, every slot shifts back.
	assign load = ctl.active && (ctl.hit ? !found_in : ctl.insert);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (load) begin
			entry_q <= prev;
		end
	end

	assign entry = entry_q;

endmodule

// ----- src/move_to_front_lru_cache.sv -----
// ----------------------------------------------------------------------------
// move_to_front_lru_cache: fully associative cache kept in recency order
// A row of cells, front first. Lookups and inserts compare all slots at
// once, move the hit entry to the front or push a new one in at the front.
// ----------------------------------------------------------------------------
// Timing: the request register takes the word at the accepting edge; the cell
//   row updates and the result register loads done and the word at the end of
//   the update cycle.
// Handshake: no new word is taken while busy is high; busy is high during the
//   update cycle, when the compare and priority chain runs across the cell row.
// Reset: arst_n empties the cache (all slots cleared) and drops any request.
// The receiver cannot stall: each result word is shown for one cycle only.
module move_to_front_lru_cache #(
	parameter int ENTRIES = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  mtf_pkg::req_t   req,
	output logic            done,
	output mtf_pkg::rsp_t   rsp
);
	import mtf_pkg::*;

	// Request register: hold the accepted word for the update cycle.
	req_t               req_q;
	logic               req_valid_q;

	// Row wiring: entries, first-match chain, matched-payload chain.
	entry_t             ent    [ENTRIES];
	entry_t             prev_w [ENTRIES];
	logic               found_c[ENTRIES+1];
	logic [PAY_W-1:0]   sel_c  [ENTRIES+1];
	logic [ENTRIES-1:0] valid_vec;

	cell_ctl_t          ctl;
	entry_t             front;
	logic               hit;
	logic               insert;
	logic [PAY_W-1:0]   matched;
	entry_t             last;
	rsp_t               rsp_d;
	rsp_t               rsp_q;
	logic               done_q;

	assign busy = req_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_q <= 1'b0;
		end else begin
			req_valid_q <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_q <= req;
		end
	end

	// Control broadcast; hit comes out of the end of the match chain.
	assign hit     = found_c[ENTRIES];
	assign matched = sel_c[ENTRIES];
	assign insert  = (req_q.action == ACT_INSERT);
	assign last    = ent[ENTRIES-1];

	always_comb begin
		ctl.active = req_valid_q;
		ctl.hit    = hit;
		ctl.insert = insert;
		ctl.key    = req_q.key;
	end

	// Word entering the front slot: the hit entry (new payload on insert)
	// or the freshly inserted key.
	always_comb begin
		front.valid   = 1'b1;
		front.key     = req_q.key;
		front.payload = (hit && !insert) ? matched : req_q.payload;
	end

	assign found_c[0] = 1'b0;
	assign sel_c[0]   = '0;

	for (genvar g = 0; g < ENTRIES; g++) begin : g_row
		if (g == 0) begin : g_head
			assign prev_w[g] = front;
		end else begin : g_body
			assign prev_w[g] = ent[g-1];
		end

		mtf_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.prev     (prev_w[g]),
			.found_in (found_c[g]),
			.sel_in   (sel_c[g]),
			.entry    (ent[g]),
			.found_out(found_c[g+1]),
			.sel_out  (sel_c[g+1])
		);

		assign valid_vec[g] = ent[g].valid;
	end

	// Result word: the hit flag, the payload found by a lookup hit, and a replaced
	// payload on an insert hit or the evicted tail entry on an insert miss into a full cache.
	always_comb begin
		rsp_d.hit              = hit;
		rsp_d.found_payload    = (hit && !insert) ? matched : '0;
		rsp_d.released_valid   = insert && (hit || last.valid);
		rsp_d.released_payload = '0;
		if (insert) begin
			if (hit) begin
				rsp_d.released_payload = matched;
			end else if (last.valid) begin
				rsp_d.released_payload = last.payload;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= req_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid_q) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// Every result follows an update cycle.
	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without an update cycle");

	// Valid slots always form a prefix of the row.
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec >> 1) & ~valid_vec) == '0)
		else $error("hole in the valid slots");

	// A release only comes from an insert, which leaves the front slot valid.
	a_release_front: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.released_valid |-> ent[0].valid)
		else $error("release with an empty front slot");

	// A miss never returns a payload.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !rsp.hit |-> rsp.found_payload == '0)
		else $error("payload returned on a miss");

endmodule

// ----- tb/tb_move_to_front_lru_cache.sv -----
// ----------------------------------------------------------------------------
// tb_move_to_front_lru_cache: self-checking bench for the move-to-front cache
// Drives lookup and insert words through the start/busy handshake, mirrors
// the recency-ordered slot row in a local predictor and checks every done
// strobe field by field against the oldest outstanding reply.
// ----------------------------------------------------------------------------
module tb_move_to_front_lru_cache;

	import mtf_pkg::*;

	localparam int ENTRIES     = 8;
	localparam int STALL_LIMIT = 300;
	localparam int RAND_BLOCKS = 12;
	localparam int BLOCK_WORDS = 100;
	localparam int POOL_MAX    = 24;

	// One queued command word plus how the sender paces it.
	typedef struct {
		req_t        word;
		int unsigned gap;    // idle cycles before this word is raised
		bit          drain;  // hold this word until every reply is back
	} cache_cmd_t;

	logic  clk    = 1'b0;
	logic  arst_n = 1'b0;
	logic  start  = 1'b0;
	req_t  req    = '0;
	logic  busy;
	logic  done;
	rsp_t  rsp;

	cache_cmd_t  cmd_q[$];
	rsp_t        replies_due[$];

	// Predictor copy of the slot row, slot 0 is most recently used.
	logic [KEY_W-1:0] slot_key   [ENTRIES];
	logic [PAY_W-1:0] slot_pay   [ENTRIES];
	logic             slot_valid [ENTRIES];

	int unsigned idle_left;
	int unsigned stall_cycles;
	int          mismatches;
	int          n_lookups, n_hits, n_inserts, n_replaced, n_evicted, n_replies;

	logic [KEY_W-1:0] key_pool [POOL_MAX];

	move_to_front_lru_cache #(
		.ENTRIES(ENTRIES)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Predictor: apply one accepted word to the slot row, return its reply.
	// ------------------------------------------------------------------------
	function automatic rsp_t predict_access(req_t w);
		rsp_t             r;
		int               hit_slot;
		int               i;
		logic [KEY_W-1:0] k;
		logic [PAY_W-1:0] p;
		r = '0;
		hit_slot = -1;
		// Scan back to front so the front-most match wins; invalid slots never match.
		for (i = ENTRIES - 1; i >= 0; i--)
			if (slot_valid[i] && slot_key[i] == w.key)
				hit_slot = i;
		if (w.action == ACT_LOOKUP)
			n_lookups++;
		else
			n_inserts++;
		if (hit_slot >= 0) begin
			k = slot_key[hit_slot];
			p = slot_pay[hit_slot];
			// Rotate the hit entry to the front, slide the ones ahead of it back.
			for (i = hit_slot; i > 0; i--) begin
				slot_key[i]   = slot_key[i-1];
				slot_pay[i]   = slot_pay[i-1];
				slot_valid[i] = slot_valid[i-1];
			end
			slot_key[0]   = k;
			slot_pay[0]   = p;
			slot_valid[0] = 1'b1;
			r.hit = 1'b1;
			if (w.action == ACT_LOOKUP) begin
				r.found_payload = p;
				n_hits++;
			end else begin
				// Present key: swap in the new handle, hand back the old one.
				r.released_valid   = 1'b1;
				r.released_payload = p;
				slot_pay[0]        = w.payload;
				n_replaced++;
			end
		end else if (w.action == ACT_INSERT) begin
			// Absent key: push everything back, drop the tail if it held an entry.
			if (slot_valid[ENTRIES-1]) begin
				r.released_valid   = 1'b1;
				r.released_payload = slot_pay[ENTRIES-1];
				n_evicted++;
			end
			for (i = ENTRIES - 1; i > 0; i--) begin
				slot_key[i]   = slot_key[i-1];
				slot_pay[i]   = slot_pay[i-1];
				slot_valid[i] = slot_valid[i-1];
			end
			slot_key[0]   = w.key;
			slot_pay[0]   = w.payload;
			slot_valid[0] = 1'b1;
		end
		// A lookup miss leaves the row alone and replies all zero.
		return r;
	endfunction

	task automatic queue_cmd(action_t act, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p,
		int unsigned gap, bit drain);
		cache_cmd_t c;
		c.word.action  = act;
		c.word.key     = k;
		c.word.payload = p;
		c.gap          = gap;
		c.drain        = drain;
		cmd_q.push_back(c);
	endtask

	// Mostly random handles, with the all-zero and all-one extremes mixed in.
	function automatic logic [PAY_W-1:0] pick_payload();
		int unsigned roll;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		return $urandom;
	endfunction

	task automatic check_field(string name, logic [PAY_W-1:0] exp_v, logic [PAY_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Driver: raise the next word once the previous one is taken and its gap
	// has passed; hold start and req steady while busy is high.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : drive_words
		cache_cmd_t c;
		if (!arst_n) begin
			start     <= 1'b0;
			req       <= '0;
			idle_left <= 0;
		end else begin
			if (start && !busy)
				replies_due.push_back(predict_access(req));
			if (!start || !busy) begin
				if (cmd_q.size() == 0) begin
					start <= 1'b0;
				end else if (cmd_q[0].drain && (replies_due.size() != 0 || done)) begin
					// Hold off until the last reply has strobed out.
					start <= 1'b0;
				end else if (idle_left < cmd_q[0].gap) begin
					start     <= 1'b0;
					idle_left <= idle_left + 1;
				end else begin
					c = cmd_q.pop_front();
					req       <= c.word;
					start     <= 1'b1;
					idle_left <= 0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: take each done strobe and compare it with the oldest reply.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : check_replies
		rsp_t e;
		if (arst_n && done) begin
			if (replies_due.size() == 0) begin
				$display("%0t: reply with none outstanding, got %h", $time, rsp);
				mismatches++;
			end else begin
				e = replies_due.pop_front();
				n_replies++;
				check_field("hit", PAY_W'(e.hit), PAY_W'(rsp.hit));
				check_field("found_payload", e.found_payload, rsp.found_payload);
				check_field("released_valid", PAY_W'(e.released_valid),
					PAY_W'(rsp.released_valid));
				check_field("released_payload", e.released_payload, rsp.released_payload);
			end
		end
	end

	// Watchdog: end the run if no word is taken and no reply shows for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin : run_test
		int               i, b, pool_n;
		int unsigned      gap;
		bit               drain;
		action_t          act;
		logic [KEY_W-1:0] k;
		mismatches   = 0;
		n_lookups    = 0;
		n_hits       = 0;
		n_inserts    = 0;
		n_replaced   = 0;
		n_evicted    = 0;
		n_replies    = 0;
		stall_cycles = 0;
		for (i = 0; i < ENTRIES; i++) begin
			slot_key[i]   = '0;
			slot_pay[i]   = '0;
			slot_valid[i] = 1'b0;
		end

		// Directed: empty cache, extremes, replace, fill, move-up, evict.
		queue_cmd(ACT_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF, 0, 0); // invalid slots hold key 0
		queue_cmd(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 0, 0);
		queue_cmd(ACT_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 0, 0);
		queue_cmd(ACT_LOOKUP, 32'h0000_0000, 32'h1234_5678, 0, 0);
		queue_cmd(ACT_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 3, 0);
		queue_cmd(ACT_INSERT, 32'h0000_0000, 32'h5A5A_A5A5, 0, 0); // replace present key
		for (i = 0; i < 6; i++)
			queue_cmd(ACT_INSERT, 32'hA5A5_0000 + i, 32'h0F0F_0000 + i, i, 0);
		queue_cmd(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0, 0, 0);   // hit deep in the row
		queue_cmd(ACT_LOOKUP, 32'h0000_0000, 32'h0, 0, 0);   // hit at the tail
		queue_cmd(ACT_INSERT, 32'h1111_1111, 32'hCAFE_0001, 0, 0); // full: evict tail
		queue_cmd(ACT_INSERT, 32'h2222_2222, 32'hCAFE_0002, 0, 0);
		queue_cmd(ACT_LOOKUP, 32'hA5A5_0000, 32'h0, 0, 0);   // evicted key misses
		queue_cmd(ACT_INSERT, 32'hA5A5_0002, 32'hFFFF_FFFF, 0, 0); // replace at the tail
		queue_cmd(ACT_INSERT, 32'h1111_1111, 32'h0000_0000, 0, 0); // replace mid-row
		queue_cmd(ACT_LOOKUP, 32'h1111_1111, 32'hFFFF_FFFF, 0, 0); // hit at the front

		// Random: keys mostly from a small pool so hits, moves and evictions recur.
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (b = 0; b < RAND_BLOCKS; b++) begin
			if (b % 4 == 0)
				for (i = 2; i < POOL_MAX; i++)
					key_pool[i] = $urandom;
			case (b % 5)
				0:       pool_n = 4;
				1:       pool_n = ENTRIES;
				2:       pool_n = ENTRIES + 1;
				3:       pool_n = 12;
				default: pool_n = POOL_MAX;
			endcase
			for (i = 0; i < BLOCK_WORDS; i++) begin
				// Every block opens by letting the cache drain completely.
				drain = (i == 0);
				if (b % 3 == 0)
					gap = 0;
				else if ($urandom_range(0, 1) == 0)
					gap = 0;
				else
					gap = $urandom_range(0, 12);
				act = ($urandom_range(0, 99) < 45) ? ACT_INSERT : ACT_LOOKUP;
				if ($urandom_range(0, 99) < 85)
					k = key_pool[$urandom_range(0, pool_n - 1)];
				else
					k = $urandom;
				queue_cmd(act, k, pick_payload(), gap, drain);
			end
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the last word to be taken, then for its reply, then settle.
		while (cmd_q.size() != 0 || start)
			@(posedge clk);
		while (replies_due.size() != 0 || done)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (replies_due.size() != 0) begin
			$display("%0t: %0d replies never arrived", $time, replies_due.size());
			mismatches++;
		end
		$display("Checked %0d replies: %0d lookups (%0d hits), %0d inserts",
			n_replies, n_lookups, n_hits, n_inserts);
		$display("Inserts replaced %0d present keys and evicted %0d tail entries",
			n_replaced, n_evicted);
		if (mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
src/mtf_pkg.sv
src/mtf_cell.sv
src/move_to_front_lru_cache.sv
tb/tb_move_to_front_lru_cache.sv
